// File: rtl/thermistor_adc_to_temperature_defines.svh
// Assertion helpers for the thermistor converter.
// THADC_ASSERT_IMP: same-cycle implication. THADC_ASSERT_NXT: next-cycle implication.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_DEFINES_SVH

`ifndef SYNTHESIS
`define THADC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define THADC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define THADC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define THADC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/thadc_pkg.sv
`timescale 1ns / 1ps
package thadc_pkg;

    localparam int ADC_BITS_DEF   = 12;
    localparam int TABLE_POINTS   = 25;
    localparam int TAB_W          = 21;   // widest table entry, tenths of an ohm
    localparam int IDX_W          = 5;    // segment index 0..TABLE_POINTS-2
    localparam int DEN_W          = 19;   // widest segment span
    localparam int QUO2_W         = 9;    // interpolation fraction 0..500
    localparam int PROD_W         = DEN_W + QUO2_W;
    localparam int TEMP_W         = 15;
    localparam int DIVIDER_TENTHS = 100000;
    localparam int T_STEP         = 500;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd10000;

    // Falling NTC resistance table, -20 C to 100 C in 5 C steps.
    localparam logic [TAB_W-1:0] RES_TAB [TABLE_POINTS] = '{
        21'd1146600, 21'd845100, 21'd629270, 21'd470770, 21'd355630,
        21'd271190,  21'd208600, 21'd162040, 21'd126830, 21'd100000,
        21'd79420,   21'd63270,  21'd50740,  21'd41030,  21'd33360,
        21'd27240,   21'd22370,  21'd18460,  21'd15300,  21'd12750,
        21'd10680,   21'd8993,   21'd7607,   21'd6452,   21'd5494
    };

    function automatic logic [DEN_W-1:0] seg_den(input logic [IDX_W-1:0] idx);
        int i;
        i = int'(idx);
        if (i < TABLE_POINTS - 1) begin
            return DEN_W'(RES_TAB[i] - RES_TAB[i + 1]);
        end
        return DEN_W'(1);
    endfunction

    function automatic logic signed [TEMP_W-1:0] seg_base(input logic [IDX_W-1:0] idx);
        return TEMP_MIN + TEMP_W'(T_STEP * int'(idx));
    endfunction

endpackage

// File: rtl/thermistor_adc_to_temperature.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// sample    in   i_valid / o_stall    i_adc_sample
// result    out  o_valid / i_stall    o_temperature_centi, o_clamped_cold, o_clamped_hot
//
// One sample per cycle while the output is not stalled. Pipeline: NUM_W stages of the
// resistance divider, five lookup stages, nine interpolation divider stages, one output stage.
// Synchronous reset clears only the stage valid bits.
// Every stage holds its item while the next one is full and stalled; empty stages keep
// filling, so bubbles close up behind a stalled output.
`include "thermistor_adc_to_temperature_defines.svh"
module thermistor_adc_to_temperature #(
    parameter int ADC_BITS = thadc_pkg::ADC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ADC_BITS-1:0]                   i_adc_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [thadc_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic                                  o_clamped_cold,
    output logic                                  o_clamped_hot
);

    localparam longint unsigned FULL_SCALE = (64'd1 << ADC_BITS) - 64'd1;
    localparam longint unsigned DIVIDEND   = FULL_SCALE * 64'(thadc_pkg::DIVIDER_TENTHS);
    localparam int              NUM_W      = $clog2(DIVIDEND + 64'd1);
    localparam int              TP         = thadc_pkg::TABLE_POINTS;
    localparam int              TEMP_W     = thadc_pkg::TEMP_W;
    localparam int              DEN_W      = thadc_pkg::DEN_W;
    localparam int              IDX_W      = thadc_pkg::IDX_W;
    localparam int              SIDE2_W    = TEMP_W + 2;

    // ---- resistance division: FULL*100000 / sample ----
    logic              d1_valid;
    logic              d1_stall;
    logic [NUM_W-1:0]  d1_quo;
    logic [ADC_BITS-1:0] d1_rem;
    logic              d1_zero;

    thadc_div #(
        .QUO_W  (NUM_W),
        .DEN_W  (ADC_BITS),
        .SIDE_W (1)
    ) u_div_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_num   ({{ADC_BITS{1'b0}}, NUM_W'(DIVIDEND)}),
        .i_den   (i_adc_sample),
        .i_side  (i_adc_sample == '0),
        .o_valid (d1_valid),
        .i_stall (d1_stall),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_zero)
    );

    // ---- stage registers ----
    logic              r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic              ready_a, ready_b, ready_c, ready_d, ready_e, ready_f;
    logic [NUM_W-1:0]  r_a_res, r_b_res, r_c_res;
    logic              r_b_cold, r_b_hot, r_c_cold, r_c_hot, r_d_cold, r_d_hot;
    logic              r_e_cold, r_e_hot;
    logic [TP-3:0]     r_b_gt;
    logic [IDX_W-1:0]  r_c_idx;
    logic [DEN_W-1:0]  r_d_diff, r_d_den, r_e_den;
    logic signed [TEMP_W-1:0] r_d_base, r_e_base;
    logic [thadc_pkg::PROD_W-1:0] r_e_prod;
    logic signed [TEMP_W-1:0] r_f_temp;
    logic              r_f_cold, r_f_hot;

    logic              d2_valid;
    logic              d2_stall;
    logic              d2_stall_up;
    logic [thadc_pkg::QUO2_W-1:0] d2_quo;
    logic [DEN_W-1:0]  d2_rem;
    logic [SIDE2_W-1:0] d2_side;

    logic [TP-3:0]     n_b_gt;
    logic [NUM_W-1:0]  n_d_diff;
    logic signed [TEMP_W-1:0] f_base, f_qext, f_sum, n_f_temp;
    logic              f_round;

    assign ready_f  = !r_f_v || !i_stall;
    assign d2_stall = !ready_f;
    assign ready_e  = !r_e_v || !d2_stall_up;
    assign ready_d  = !r_d_v || ready_e;
    assign ready_c  = !r_c_v || ready_d;
    assign ready_b  = !r_b_v || ready_c;
    assign ready_a  = !r_a_v || ready_b;
    assign d1_stall = !ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (ready_a) r_a_v <= d1_valid;
            if (ready_b) r_b_v <= r_a_v;
            if (ready_c) r_c_v <= r_b_v;
            if (ready_d) r_d_v <= r_c_v;
            if (ready_e) r_e_v <= r_d_v;
            if (ready_f) r_f_v <= d2_valid;
        end
    end

    // Stage A: resistance in tenths of an ohm; a zero sample reads as the table top.
    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_res <= d1_zero ? NUM_W'(thadc_pkg::RES_TAB[0])
                               : d1_quo - NUM_W'(thadc_pkg::DIVIDER_TENTHS);
        end
    end

    // Stage B: compare against every table point at once.
    always_comb begin
        for (int j = 1; j <= TP - 2; j++) begin
            n_b_gt[j-1] = NUM_W'(thadc_pkg::RES_TAB[j]) > r_a_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b) begin
            r_b_res  <= r_a_res;
            r_b_cold <= r_a_res >= NUM_W'(thadc_pkg::RES_TAB[0]);
            r_b_hot  <= r_a_res <= NUM_W'(thadc_pkg::RES_TAB[TP-1]);
            r_b_gt   <= n_b_gt;
        end
    end

    // Stage C: the falling table makes the compare vector a thermometer code.
    always_ff @(posedge i_clk) begin
        if (ready_c) begin
            r_c_res  <= r_b_res;
            r_c_cold <= r_b_cold;
            r_c_hot  <= r_b_hot && !r_b_cold;
            r_c_idx  <= IDX_W'($countones(r_b_gt));
        end
    end

    // Stage D: offset into the segment, segment span and base temperature.
    assign n_d_diff = NUM_W'(thadc_pkg::RES_TAB[r_c_idx]) - r_c_res;

    always_ff @(posedge i_clk) begin
        if (ready_d) begin
            r_d_diff <= DEN_W'(n_d_diff);
            r_d_den  <= thadc_pkg::seg_den(r_c_idx);
            r_d_base <= thadc_pkg::seg_base(r_c_idx);
            r_d_cold <= r_c_cold;
            r_d_hot  <= r_c_hot;
        end
    end

    // Stage E: scale the offset by the 5 C step.
    always_ff @(posedge i_clk) begin
        if (ready_e) begin
            r_e_prod <= thadc_pkg::PROD_W'(r_d_diff) *
                        thadc_pkg::PROD_W'(thadc_pkg::T_STEP);
            r_e_den  <= r_d_den;
            r_e_base <= r_d_base;
            r_e_cold <= r_d_cold;
            r_e_hot  <= r_d_hot;
        end
    end

    // ---- interpolation division: offset*500 / span ----
    thadc_div #(
        .QUO_W  (thadc_pkg::QUO2_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE2_W)
    ) u_div_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_v),
        .o_stall (d2_stall_up),
        .i_num   (r_e_prod),
        .i_den   (r_e_den),
        .i_side  ({r_e_base, r_e_cold, r_e_hot}),
        .o_valid (d2_valid),
        .i_stall (d2_stall),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // Stage F: base + fraction, truncated toward zero, then clamps.
    always_comb begin
        f_base  = d2_side[SIDE2_W-1:2];
        f_qext  = $signed(TEMP_W'(d2_quo));
        f_sum   = f_base + f_qext;
        // negative with a nonzero fraction: floor is one below truncation
        f_round = f_sum[TEMP_W-1] && (d2_rem != '0);
        if (d2_side[1]) begin
            n_f_temp = thadc_pkg::TEMP_MIN;
        end else if (d2_side[0]) begin
            n_f_temp = thadc_pkg::TEMP_MAX;
        end else begin
            n_f_temp = f_sum + $signed(TEMP_W'(f_round));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_f) begin
            r_f_temp <= n_f_temp;
            r_f_cold <= d2_side[1];
            r_f_hot  <= d2_side[0];
        end
    end

    assign o_valid             = r_f_v;
    assign o_temperature_centi = r_f_temp;
    assign o_clamped_cold      = r_f_cold;
    assign o_clamped_hot       = r_f_hot;

    `THADC_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, o_valid, !(o_clamped_cold && o_clamped_hot), "both clamp flags set")
    `THADC_ASSERT_IMP(a_cold_value, i_clk, i_rst_n, o_valid && o_clamped_cold, o_temperature_centi == thadc_pkg::TEMP_MIN, "cold clamp value wrong")
    `THADC_ASSERT_IMP(a_hot_value, i_clk, i_rst_n, o_valid && o_clamped_hot, o_temperature_centi == thadc_pkg::TEMP_MAX, "hot clamp value wrong")
    `THADC_ASSERT_IMP(a_range, i_clk, i_rst_n, o_valid, (o_temperature_centi >= thadc_pkg::TEMP_MIN) && (o_temperature_centi <= thadc_pkg::TEMP_MAX), "temperature out of range")
    `THADC_ASSERT_NXT(a_lookup_hold, i_clk, i_rst_n, r_e_v && d2_stall_up, r_e_v && $stable(r_e_prod), "interpolation input lost under stall")

endmodule

// File: rtl/thadc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Requires the top DEN_W bits of the dividend to be below the divisor.
module thadc_div #(
    parameter int QUO_W  = 9,
    parameter int DEN_W  = 19,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [DEN_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]         i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [QUO_W-1:0]         o_quo,
    output logic [DEN_W-1:0]         o_rem,
    output logic [SIDE_W-1:0]        o_side
);

    logic              r_v    [QUO_W];
    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_lo   [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    logic              src_v    [QUO_W];
    logic [DEN_W-1:0]  src_rem  [QUO_W];
    logic [QUO_W-1:0]  src_lo   [QUO_W];
    logic [DEN_W-1:0]  src_den  [QUO_W];
    logic [SIDE_W-1:0] src_side [QUO_W];

    logic [QUO_W:0]    ready;

    assign src_v[0]    = i_valid;
    assign src_rem[0]  = i_num[DEN_W+QUO_W-1:QUO_W];
    assign src_lo[0]   = i_num[QUO_W-1:0];
    assign src_den[0]  = i_den;
    assign src_side[0] = i_side;

    assign ready[QUO_W] = !i_stall;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [QUO_W-1:0] n_lo;

        if (k > 0) begin : g_link
            assign src_v[k]    = r_v[k-1];
            assign src_rem[k]  = r_rem[k-1];
            assign src_lo[k]   = r_lo[k-1];
            assign src_den[k]  = r_den[k-1];
            assign src_side[k] = r_side[k-1];
        end

        assign ready[k] = !r_v[k] || ready[k+1];

        always_comb begin
            trial = {src_rem[k], src_lo[k][QUO_W-1]} - {1'b0, src_den[k]};
            ge    = !trial[DEN_W];
            n_rem = ge ? trial[DEN_W-1:0] : {src_rem[k][DEN_W-2:0], src_lo[k][QUO_W-1]};
            n_lo  = {src_lo[k][QUO_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (ready[k]) begin
                r_v[k] <= src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ready[k]) begin
                r_rem[k]  <= n_rem;
                r_lo[k]   <= n_lo;
                r_den[k]  <= src_den[k];
                r_side[k] <= src_side[k];
            end
        end
    end

    assign o_stall = !ready[0];
    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_lo[QUO_W-1];
    assign o_rem   = r_rem[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

// File: tb/tb_thermistor_adc_to_temperature.sv
`timescale 1ns / 1ps
module tb_thermistor_adc_to_temperature;

    localparam int     SAMPLE_W      = 12;
    localparam int     TEMP_W        = thadc_pkg::TEMP_W;
    localparam longint FULL_SCALE    = (64'd1 << SAMPLE_W) - 1;
    localparam longint DIVIDER       = 100000;
    localparam int     POINTS        = 25;
    localparam int     DRAIN_CYCLES  = 80;    // pipeline is 44 deep at 12 bits
    localparam int     WATCHDOG_MAX  = 5000;
    localparam int     HOLDOFF_LEN   = 300;

    // Falling NTC curve in tenths of an ohm, -20 C .. 100 C in 5 C steps
    localparam longint NTC_CURVE [POINTS] = '{
        1146600, 845100, 629270, 470770, 355630, 271190, 208600, 162040,
        126830, 100000, 79420, 63270, 50740, 41030, 33360, 27240,
        22370, 18460, 15300, 12750, 10680, 8993, 7607, 6452, 5494
    };

    typedef struct {
        logic signed [TEMP_W-1:0] centi;
        logic                     cold;
        logic                     hot;
    } t_temp_reading;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [SAMPLE_W-1:0]       i_adc_sample = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [TEMP_W-1:0]  o_temperature_centi;
    logic                      o_clamped_cold;
    logic                      o_clamped_hot;

    t_temp_reading expected_temps[$];
    int            fail_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            holdoff_req = 0;
    int            holdoff_left = 0;
    int            quiet_cycles = 0;

    thermistor_adc_to_temperature #(.ADC_BITS(SAMPLE_W)) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_adc_sample        (i_adc_sample),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_clamped_cold      (o_clamped_cold),
        .o_clamped_hot       (o_clamped_hot)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_temp_reading predict_temperature(input logic [SAMPLE_W-1:0] sample);
        longint        r;
        longint        den;
        longint        num;
        longint        base;
        int            seg;
        t_temp_reading t;
        t.centi = '0;
        t.cold  = 1'b0;
        t.hot   = 1'b0;
        // zero reading means open divider: treat as coldest point
        if (sample == '0) r = NTC_CURVE[0];
        else r = (FULL_SCALE * DIVIDER) / longint'(sample) - DIVIDER;
        if (r >= NTC_CURVE[0]) begin
            t.centi = -15'sd2000;
            t.cold  = 1'b1;
        end else if (r <= NTC_CURVE[POINTS-1]) begin
            t.centi = 15'sd10000;
            t.hot   = 1'b1;
        end else begin
            seg = -1;
            for (int k = 0; k < POINTS - 1; k++) begin
                if (seg < 0 && r <= NTC_CURVE[k] && r >= NTC_CURVE[k+1]) seg = k;
            end
            if (seg >= 0) begin
                den  = NTC_CURVE[seg] - NTC_CURVE[seg+1];
                base = -2000 + 500 * seg;
                num  = base * den + (NTC_CURVE[seg] - r) * 500;
                t.centi = TEMP_W'(num / den);
            end
        end
        return t;
    endfunction

    // sample whose resistance lands on (or just past) a curve point
    function automatic logic [SAMPLE_W-1:0] sample_at_point(input int idx);
        return SAMPLE_W'((FULL_SCALE * DIVIDER) / (NTC_CURVE[idx] + DIVIDER));
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        i_valid      <= 1'b1;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (o_stall);
        expected_temps.push_back(predict_temperature(sample));
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_adc_sample <= SAMPLE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) return SAMPLE_W'($urandom);
        if (pick < 32) return SAMPLE_W'($urandom_range(328));
        if (pick < 39) return SAMPLE_W'($urandom_range(4095, 3882));
        if (pick < 47) return sample_at_point($urandom_range(POINTS - 1))
                              + SAMPLE_W'($urandom_range(2)) - 1'b1;
        return SAMPLE_W'($urandom_range(3881, 329));
    endfunction

    // result side: check each transfer, then decide the next stall
    always @(posedge i_clk) begin
        t_temp_reading want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_temps.size() == 0) begin
                    $error("unexpected result: temperature_centi=%0d", o_temperature_centi);
                    fail_count++;
                end else begin
                    want = expected_temps.pop_front();
                    if (o_temperature_centi !== want.centi) begin
                        $error("temperature_centi: expected %0d, got %0d",
                               want.centi, o_temperature_centi);
                        fail_count++;
                    end
                    if (o_clamped_cold !== want.cold) begin
                        $error("clamped_cold: expected %0b, got %0b", want.cold, o_clamped_cold);
                        fail_count++;
                    end
                    if (o_clamped_hot !== want.hot) begin
                        $error("clamped_hot: expected %0b, got %0b", want.hot, o_clamped_hot);
                        fail_count++;
                    end
                end
            end
            if (holdoff_req != 0) begin
                holdoff_left = holdoff_req;
                holdoff_req  = 0;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (expected_temps.size() == 0 && !i_valid)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_directed_corners();
        logic [SAMPLE_W-1:0] corners[$];
        corners = '{12'd0, 12'd1, 12'd328, 12'd329, 12'd330, 12'd3881, 12'd3882,
                    12'd3883, 12'd4094, 12'd4095, 12'd2048, 12'hAAA, 12'h555};
        foreach (corners[k]) send_sample(corners[k]);
        // land on every fourth interior curve point, on both sides of its segment edge
        for (int p = 1; p < POINTS - 1; p += 4) begin
            send_sample(sample_at_point(p));
            send_sample(sample_at_point(p) + 1'b1);
        end
    endtask

    task automatic test_random_samples(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    // long output hold-off while samples keep coming: pipeline fills and stalls input
    task automatic test_output_holdoff();
        holdoff_req = HOLDOFF_LEN;
        repeat (90) send_sample(random_sample());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 23;
        recv_idle_pct = 86;
        test_directed_corners();
        test_random_samples(300);

        send_idle_pct = 86;
        recv_idle_pct = 23;
        test_random_samples(280);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_samples(260);
        test_output_holdoff();

        i_valid <= 1'b0;
        while (expected_temps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/thadc_pkg.sv
rtl/thadc_div.sv
rtl/thermistor_adc_to_temperature.sv
tb/tb_thermistor_adc_to_temperature.sv
